[hdl/sorted_table_binary_search_unit_defines.svh]
// Assertion macros for the sorted table binary search unit.
// Used by the checker; depends on nothing else.
`ifndef SORTED_TABLE_BINARY_SEARCH_UNIT_DEFINES_SVH
`define SORTED_TABLE_BINARY_SEARCH_UNIT_DEFINES_SVH

// Same-cycle implication, switched off while reset is held.
`define STBS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stbs check failed");

// Next-cycle implication, switched off while reset is held.
`define STBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stbs check failed");

`endif

[hdl/stbs_pkg.sv]
// Shared types and constants for the sorted table binary search unit.
// No dependencies; the files that use it refer to it by scoped names.
`default_nettype none

package stbs_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int VALUE_W         = 32;
    localparam int INDEX_W         = 10;
    localparam int LEN_W           = 11;
    localparam int PROBE_W         = 4;
    localparam int MAX_PROBES      = 11;

    typedef enum logic {
        KIND_LOAD  = 1'b0,
        KIND_QUERY = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_WRITE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_wr;
        logic query_start;
        logic step_left;
        logic step_right;
        logic record_hit;
        logic record_miss;
        logic publish;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic len_zero;
        logic key_eq;
        logic key_lt;
        logic can_left;
        logic can_right;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

[hdl/stbs_if.sv]
// Channel interfaces of the sorted table binary search unit: items in,
// results out and the table length write port. Depends on stbs_pkg.
`default_nettype none

interface stbs_in_if;
    logic                                valid;
    logic                                ready;
    logic                                kind;
    logic [stbs_pkg::INDEX_W-1:0]        load_index;
    logic signed [stbs_pkg::VALUE_W-1:0] load_value;
    logic signed [stbs_pkg::VALUE_W-1:0] search_key;

    modport source (output valid, kind, load_index, load_value, search_key, input ready);
    modport sink   (input valid, kind, load_index, load_value, search_key, output ready);
endinterface

interface stbs_out_if;
    logic                         valid;
    logic                         ready;
    logic                         found;
    logic [stbs_pkg::INDEX_W-1:0] position;
    logic [stbs_pkg::PROBE_W-1:0] probe_count;

    modport source (output valid, found, position, probe_count, input ready);
    modport sink   (input valid, found, position, probe_count, output ready);
endinterface

interface stbs_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [stbs_pkg::LEN_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

[hdl/stbs_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module stbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

[hdl/stbs_ctrl.sv]
// Controller of the sorted table binary search unit: sequences loads,
// probes and result hand-off. Depends on stbs_pkg.
`default_nettype none

module stbs_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire logic           i_kind,
    input  wire stbs_pkg::t_sts i_sts,
    output logic                o_in_ready,
    output stbs_pkg::t_cmd      o_cmd
);

    stbs_pkg::t_state r_state;
    stbs_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= stbs_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            stbs_pkg::ST_IDLE: begin
                if (i_in_valid && i_kind == stbs_pkg::KIND_QUERY) begin
                    n_state = i_sts.len_zero ? stbs_pkg::ST_WRITE : stbs_pkg::ST_PROBE;
                end
            end
            stbs_pkg::ST_PROBE: begin
                if (i_sts.key_eq) begin
                    n_state = stbs_pkg::ST_WRITE;
                end else if (i_sts.key_lt ? !i_sts.can_left : !i_sts.can_right) begin
                    n_state = stbs_pkg::ST_WRITE;
                end
            end
            stbs_pkg::ST_WRITE: begin
                if (i_sts.out_free) begin
                    n_state = stbs_pkg::ST_IDLE;
                end
            end
            default: n_state = stbs_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            stbs_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_kind == stbs_pkg::KIND_QUERY) begin
                        o_cmd.query_start = 1'b1;
                    end else begin
                        o_cmd.load_wr = 1'b1;
                    end
                end
            end
            stbs_pkg::ST_PROBE: begin
                // Each probe either narrows the range and reads again or ends the search.
                if (i_sts.key_eq) begin
                    o_cmd.record_hit = 1'b1;
                end else if (i_sts.key_lt) begin
                    if (i_sts.can_left) begin
                        o_cmd.step_left = 1'b1;
                    end else begin
                        o_cmd.record_miss = 1'b1;
                    end
                end else begin
                    if (i_sts.can_right) begin
                        o_cmd.step_right = 1'b1;
                    end else begin
                        o_cmd.record_miss = 1'b1;
                    end
                end
            end
            stbs_pkg::ST_WRITE: begin
                o_cmd.publish = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

[hdl/stbs_datapath.sv]
// Datapath of the sorted table binary search unit: table memory, search
// bounds, key compare and result register. Depends on stbs_pkg and stbs_ram.
`default_nettype none

module stbs_datapath #(
    parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire stbs_pkg::t_cmd                      i_cmd,
    output stbs_pkg::t_sts                           o_sts,
    input  wire logic [stbs_pkg::INDEX_W-1:0]        i_load_index,
    input  wire logic signed [stbs_pkg::VALUE_W-1:0] i_load_value,
    input  wire logic signed [stbs_pkg::VALUE_W-1:0] i_search_key,
    input  wire logic                                i_cfg_valid,
    input  wire logic [stbs_pkg::LEN_W-1:0]          i_cfg_data,
    output logic                                     o_cfg_ready,
    input  wire logic                                i_out_ready,
    output logic                                     o_out_valid,
    output logic                                     o_found,
    output logic [stbs_pkg::INDEX_W-1:0]             o_position,
    output logic [stbs_pkg::PROBE_W-1:0]             o_probe_count
);

    localparam int LW = stbs_pkg::LEN_W;
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int XW = (AW > LW) ? AW : LW;

    logic [LW-1:0]                       r_table_length;
    logic signed [stbs_pkg::VALUE_W-1:0] r_key;
    logic [LW-1:0]                       r_lo;
    logic [LW-1:0]                       r_hix;   // upper bound, one past the last candidate
    logic [LW-1:0]                       r_mid;
    logic [stbs_pkg::PROBE_W-1:0]        r_probes;
    logic                                r_hit;
    logic                                r_out_valid;
    logic                                r_found;
    logic [stbs_pkg::INDEX_W-1:0]        r_position;
    logic [stbs_pkg::PROBE_W-1:0]        r_probe_count;

    logic [LW-1:0]                       eff_len;
    logic [LW-1:0]                       mid_first;
    logic [LW:0]                         sum_left;
    logic [LW:0]                         sum_right;
    logic [LW:0]                         mid_inc;
    logic [LW-1:0]                       mid_left;
    logic [LW-1:0]                       mid_right;
    logic [LW-1:0]                       mid_sel;
    logic [XW-1:0]                       rd_addr_x;
    logic [XW-1:0]                       wr_addr_x;
    logic                                rd_en;
    logic                                wr_en;
    logic signed [stbs_pkg::VALUE_W-1:0] rd_data;

    // A length beyond the table depth covers the whole table.
    assign eff_len   = (int'(r_table_length) > TABLE_DEPTH) ? LW'(TABLE_DEPTH) : r_table_length;
    assign mid_first = (eff_len - LW'(1)) >> 1;

    // Both possible next midpoints are formed alongside the compare.
    assign sum_left  = {1'b0, r_lo} + {1'b0, r_mid} - (LW+1)'(1);
    assign sum_right = {1'b0, r_mid} + {1'b0, r_hix};
    assign mid_inc   = {1'b0, r_mid} + (LW+1)'(1);
    assign mid_left  = sum_left[LW:1];
    assign mid_right = sum_right[LW:1];

    always_comb begin
        if (i_cmd.step_left) begin
            mid_sel = mid_left;
        end else if (i_cmd.step_right) begin
            mid_sel = mid_right;
        end else begin
            mid_sel = mid_first;
        end
    end

    assign rd_addr_x = XW'(mid_sel);
    assign wr_addr_x = XW'(i_load_index);
    assign rd_en     = (i_cmd.query_start && eff_len != '0) || i_cmd.step_left
                       || i_cmd.step_right;
    assign wr_en     = i_cmd.load_wr && (int'(i_load_index) < TABLE_DEPTH);

    stbs_ram #(
        .WIDTH (stbs_pkg::VALUE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr_x[AW-1:0]),
        .i_wr_data (i_load_value),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr_x[AW-1:0]),
        .o_rd_data (rd_data)
    );

    assign o_sts.len_zero  = (eff_len == '0);
    assign o_sts.key_eq    = (r_key == rd_data);
    assign o_sts.key_lt    = (r_key < rd_data);
    assign o_sts.can_left  = (r_lo < r_mid);
    assign o_sts.can_right = (mid_inc < {1'b0, r_hix});
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_length <= '0;
        end else if (i_cfg_valid) begin
            r_table_length <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.publish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.query_start) begin
            r_key    <= i_search_key;
            r_lo     <= '0;
            r_hix    <= eff_len;
            r_mid    <= mid_first;
            r_probes <= (eff_len == '0) ? '0 : stbs_pkg::PROBE_W'(1);
            r_hit    <= 1'b0;
        end else if (i_cmd.step_left) begin
            r_hix    <= r_mid;
            r_mid    <= mid_left;
            r_probes <= r_probes + stbs_pkg::PROBE_W'(1);
        end else if (i_cmd.step_right) begin
            r_lo     <= mid_inc[LW-1:0];
            r_mid    <= mid_right;
            r_probes <= r_probes + stbs_pkg::PROBE_W'(1);
        end else if (i_cmd.record_hit) begin
            r_hit <= 1'b1;
        end else if (i_cmd.record_miss) begin
            r_hit <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.publish) begin
            r_found       <= r_hit;
            r_position    <= r_hit ? r_mid[stbs_pkg::INDEX_W-1:0] : '0;
            r_probe_count <= r_probes;
        end
    end

    assign o_cfg_ready   = 1'b1;
    assign o_out_valid   = r_out_valid;
    assign o_found       = r_found;
    assign o_position    = r_position;
    assign o_probe_count = r_probe_count;

endmodule

`default_nettype wire

[hdl/sorted_table_binary_search_unit.sv]
// Top level of the sorted table binary search unit.
// Depends on stbs_pkg, stbs_if, stbs_ctrl and stbs_datapath.
//
// Usage: i_item carries one item per valid/ready handshake. A load item
// (kind 0) writes load_value at load_index and gives no result; an index
// at or beyond the table depth is dropped. A query item (kind 1) searches
// the first table_length entries for search_key and gives one result on
// o_result: found, position (0 on a miss) and probe_count. i_cfg writes
// table_length; it is always ready and should be written only when idle.
// A load is written to the table as it is accepted. A query is accepted,
// probes the table (at most 11 probes at the default depth) and then moves
// its result into the output register, which drives o_result.
// The single read port of the table memory sets the pace of one probe per
// cycle; the next item is taken once the controller is back in idle.
// Reset clears table_length to 0 and empties the output register; table
// contents are undefined until loaded. While o_result is stalled the
// result holds, loads and a new query may still be accepted, and that
// query waits with its result until the output register is free.
`default_nettype none

module sorted_table_binary_search_unit #(
    parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    stbs_in_if.sink     i_item,
    stbs_cfg_if.sink    i_cfg,
    stbs_out_if.source  o_result
);

    stbs_pkg::t_cmd cmd;
    stbs_pkg::t_sts sts;

    stbs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .i_kind     (i_item.kind),
        .i_sts      (sts),
        .o_in_ready (i_item.ready),
        .o_cmd      (cmd)
    );

    stbs_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_load_index  (i_item.load_index),
        .i_load_value  (i_item.load_value),
        .i_search_key  (i_item.search_key),
        .i_cfg_valid   (i_cfg.valid),
        .i_cfg_data    (i_cfg.data),
        .o_cfg_ready   (i_cfg.ready),
        .i_out_ready   (o_result.ready),
        .o_out_valid   (o_result.valid),
        .o_found       (o_result.found),
        .o_position    (o_result.position),
        .o_probe_count (o_result.probe_count)
    );

endmodule

`default_nettype wire

[hdl/stbs_checker.sv]
// Port-level checks on the result channel of the search unit, bound to
// the top level. Depends on stbs_pkg and the assertion macro header.
`default_nettype none
`include "sorted_table_binary_search_unit_defines.svh"

module stbs_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_out_valid,
    input wire logic                         i_out_ready,
    input wire logic                         i_found,
    input wire logic [stbs_pkg::INDEX_W-1:0] i_position,
    input wire logic [stbs_pkg::PROBE_W-1:0] i_probe_count
);

    // A stalled result stays offered.
    `STBS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)

    // A miss reports position zero.
    `STBS_ASSERT_IMPL(a_miss_pos, i_clk, i_rst_n, i_out_valid && !i_found, i_position == '0)

    // A hit needs at least one probe.
    `STBS_ASSERT_IMPL(a_hit_probe, i_clk, i_rst_n, i_out_valid && i_found, i_probe_count != '0)

    // The probe count is bounded by the largest searchable length.
    `STBS_ASSERT_IMPL(a_probe_max, i_clk, i_rst_n, i_out_valid, i_probe_count <= stbs_pkg::PROBE_W'(stbs_pkg::MAX_PROBES))

endmodule

bind sorted_table_binary_search_unit stbs_checker u_stbs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_result.valid),
    .i_out_ready   (o_result.ready),
    .i_found       (o_result.found),
    .i_position    (o_result.position),
    .i_probe_count (o_result.probe_count)
);

`default_nettype wire
